@@ design/lhpf_pkg.sv @@
// shared types and constants of the loop play head controller
package lhpf_pkg;

	localparam int PHASE_W = 48;
	localparam int RATE_W  = 32;
	localparam int LOOP_W  = 40;
	localparam int FADE_W  = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;

	localparam logic [FADE_W-1:0] FADE_ONE    = FADE_W'(65536);
	localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(65536);

	typedef enum logic [1:0] {
		MODE_INACTIVE = 2'd0,
		MODE_FADE_IN  = 2'd1,
		MODE_ACTIVE   = 2'd2,
		MODE_FADE_OUT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REQ_TICK      = 2'd0,
		REQ_SET_MODE  = 2'd1,
		REQ_SET_PHASE = 2'd2,
		REQ_NONE      = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_LOOP_FWD = 2'd1,
		ACT_LOOP_BWD = 2'd2,
		ACT_STOP     = 2'd3
	} action_t;

	localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_START  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_END    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_ENABLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_INC    = 3'd5;

	typedef struct packed {
		logic [RATE_W-1:0] rate_step;
		logic [LOOP_W-1:0] loop_start;
		logic [LOOP_W-1:0] loop_end;
		logic              loop_enable;
		logic              head_enable;
		logic [FADE_W-1:0] fade_increment;
	} cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [FADE_W-1:0]  fade;
		mode_t              mode;
	} state_t;

	typedef struct packed {
		req_t               req;
		mode_t              new_mode;
		logic [PHASE_W-1:0] new_position;
	} item_t;

	typedef struct packed {
		action_t act;
		logic    trig;
	} event_t;

endpackage

@@ design/loop_head_phase_fade.sv @@
// top level of the loop play head controller
//
// Requests arrive on the in channel (in_valid/in_ready) as req_type,
// new_mode and new_position; each request gives exactly one result on the
// out channel (out_valid/out_ready): action, trigger, position, fade_level
// and mode after the request.
// Registers are written on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high and unknown indexes are dropped.
// A request is held in an input register, then the step logic updates phase,
// fade and mode and loads the result register once that register is empty
// or out_ready is high.
// One request per cycle is accepted while the receiver does not stall; the
// next state from the phase adder and fade ramp is formed combinationally.
// When the receiver stalls, the result register holds its transfer and
// the input register fills; in_ready then drops until out_ready returns.
// Reset clears phase, fade and mode to zero/inactive, empties both
// registers and loads the register defaults (rate_step one frame per tick).
module loop_head_phase_fade import lhpf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            req_type,
	input  logic [1:0]            new_mode,
	input  logic [PHASE_W-1:0]    new_position,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            action,
	output logic                  trigger,
	output logic [PHASE_W-1:0]    position,
	output logic [FADE_W-1:0]     fade_level,
	output logic [1:0]            mode,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg;
	item_t  item_s1;
	logic   valid_s1;
	state_t state_q;
	state_t state_nxt;
	event_t evt;
	event_t evt_s2;
	logic   valid_s2;
	logic   advance;

	assign cfg_ready = 1'b1;

	lhpf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lhpf_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.evt  (evt)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.req          <= req_t'(req_type);
			item_s1.new_mode     <= mode_t'(new_mode);
			item_s1.new_position <= new_position;
		end
	end

	// head state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= '0;
			state_q.fade  <= '0;
			state_q.mode  <= MODE_INACTIVE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			evt_s2 <= evt;
		end
	end

	assign out_valid  = valid_s2;
	assign action     = evt_s2.act;
	assign trigger    = evt_s2.trig;
	assign position   = state_q.phase;
	assign fade_level = state_q.fade;
	assign mode       = state_q.mode;

endmodule

@@ design/lhpf_cfg.sv @@
// configuration register file
module lhpf_cfg import lhpf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_step      <= RATE_RESET;
			cfg_q.loop_start     <= '0;
			cfg_q.loop_end       <= '0;
			cfg_q.loop_enable    <= 1'b0;
			cfg_q.head_enable    <= 1'b0;
			cfg_q.fade_increment <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RATE_STEP:   cfg_q.rate_step      <= cfg_data[RATE_W-1:0];
				REG_LOOP_START:  cfg_q.loop_start     <= cfg_data[LOOP_W-1:0];
				REG_LOOP_END:    cfg_q.loop_end       <= cfg_data[LOOP_W-1:0];
				REG_LOOP_ENABLE: cfg_q.loop_enable    <= cfg_data[0];
				REG_HEAD_ENABLE: cfg_q.head_enable    <= cfg_data[0];
				REG_FADE_INC:    cfg_q.fade_increment <= cfg_data[FADE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/lhpf_step.sv @@
// next-state logic: phase step, range check and fade ramp, plus set-mode and set-phase requests
module lhpf_step import lhpf_pkg::*; (
	input  item_t  item,
	input  state_t cur,
	input  cfg_t   cfg,
	output state_t nxt,
	output event_t evt
);

	logic [PHASE_W-1:0] phase_sum;
	logic               rate_positive;
	logic               out_of_range;
	mode_t              mid_mode;
	logic [FADE_W:0]    fade_sum;
	logic [FADE_W:0]    fade_diff;

	always_comb begin
		phase_sum = cur.phase + {{(PHASE_W-RATE_W){cfg.rate_step[RATE_W-1]}}, cfg.rate_step};
		rate_positive = (cfg.rate_step != '0) && !cfg.rate_step[RATE_W-1];
		out_of_range =
			($signed(phase_sum) > $signed({{(PHASE_W-LOOP_W){1'b0}}, cfg.loop_end})) ||
			($signed(phase_sum) < $signed({{(PHASE_W-LOOP_W){1'b0}}, cfg.loop_start}));
		fade_sum  = {1'b0, cur.fade} + {1'b0, cfg.fade_increment};
		fade_diff = {1'b0, cur.fade} - {1'b0, cfg.fade_increment};

		nxt      = cur;
		evt.act  = ACT_NONE;
		evt.trig = 1'b0;
		mid_mode = cur.mode;

		case (item.req)
			REQ_TICK: begin
				// phase step
				if (cur.mode != MODE_INACTIVE) begin
					nxt.phase = phase_sum;
					if (cfg.head_enable && out_of_range) begin
						if (cfg.loop_enable) begin
							evt.trig = 1'b1;
							evt.act  = rate_positive ? ACT_LOOP_FWD : ACT_LOOP_BWD;
						end else begin
							mid_mode = MODE_FADE_OUT;
							evt.act  = ACT_STOP;
						end
					end
				end
				// fade step
				nxt.mode = mid_mode;
				if (mid_mode == MODE_FADE_IN) begin
					if (fade_sum > {1'b0, FADE_ONE}) begin
						nxt.fade = FADE_ONE;
						nxt.mode = MODE_ACTIVE;
					end else begin
						nxt.fade = fade_sum[FADE_W-1:0];
					end
				end else if (mid_mode == MODE_FADE_OUT) begin
					if (fade_diff[FADE_W]) begin
						nxt.fade = '0;
						nxt.mode = MODE_INACTIVE;
					end else begin
						nxt.fade = fade_diff[FADE_W-1:0];
					end
				end
			end
			REQ_SET_MODE:  nxt.mode  = item.new_mode;
			REQ_SET_PHASE: nxt.phase = item.new_position;
			default: ;
		endcase
	end

endmodule
